// ----- hdl/slc_pkg.sv -----
package slc_pkg;

  // Default sizing of the store
  localparam int unsigned MAX_SET_BITS_DEF = 6;
  localparam int unsigned MAX_WAYS_DEF     = 8;
  localparam int unsigned ADDR_WIDTH_DEF   = 64;

  // Field widths
  localparam int unsigned OP_W         = 2;
  localparam int unsigned SET_BITS_W   = 3;
  localparam int unsigned WAYS_W       = 4;
  localparam int unsigned BLOCK_BITS_W = 6;
  localparam int unsigned TOTAL_W      = 32;

  // Config port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] REG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_STORE  = 2'd1,
    OP_MODIFY = 2'd2,
    OP_FETCH  = 2'd3
  } op_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;  // word taken: latch it, read its set row
    logic commit;   // row data ready and output free: write back unless fetch, load result
  } cmd_t;

  typedef struct packed {
    logic               hit;
    logic               miss;
    logic               eviction;
    logic               second_hit;
    logic [TOTAL_W-1:0] hit_total;
    logic [TOTAL_W-1:0] miss_total;
    logic [TOTAL_W-1:0] eviction_total;
  } result_t;

endpackage

// ----- hdl/slc_ifs.sv -----
interface slc_item_if #(
  parameter int unsigned ADDR_WIDTH = slc_pkg::ADDR_WIDTH_DEF
);
  logic                       valid;
  logic                       ready;
  logic [slc_pkg::OP_W-1:0]   operation;
  logic [ADDR_WIDTH-1:0]      address;

  modport source (output valid, output operation, output address, input ready);
  modport sink (input valid, input operation, input address, output ready);
endinterface

interface slc_result_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic                          miss;
  logic                          eviction;
  logic                          second_hit;
  logic [slc_pkg::TOTAL_W-1:0]   hit_total;
  logic [slc_pkg::TOTAL_W-1:0]   miss_total;
  logic [slc_pkg::TOTAL_W-1:0]   eviction_total;

  modport source (output valid, output hit, output miss, output eviction, output second_hit,
                  output hit_total, output miss_total, output eviction_total, input ready);
  modport sink (input valid, input hit, input miss, input eviction, input second_hit,
                input hit_total, input miss_total, input eviction_total, output ready);
endinterface

interface slc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [slc_pkg::CFG_IDX_W-1:0]    index;
  logic [slc_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hdl/slc_ram.sv -----
module slc_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/slc_ctrl.sv -----
module slc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output slc_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_LOOKUP = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   capture;
  logic   commit;

  assign in_ready_o = (state_q == ST_IDLE);
  assign capture    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign commit     = (state_q == ST_LOOKUP) && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (capture) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (commit) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign cmd_o.capture  = capture;
  assign cmd_o.commit   = commit;

`ifndef SYNTHESIS
  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_q)
    else $error("result not presented after commit");
  a_capture_looks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    capture |=> (state_q == ST_LOOKUP))
    else $error("no lookup after capture");
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_LOOKUP) && !out_free) |=> (state_q == ST_LOOKUP))
    else $error("lookup dropped while output blocked");
  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(capture && commit))
    else $error("capture and commit together");
`endif

endmodule

// ----- hdl/slc_dp.sv -----
module slc_dp #(
  parameter int unsigned MAX_SET_BITS = slc_pkg::MAX_SET_BITS_DEF,
  parameter int unsigned MAX_WAYS     = slc_pkg::MAX_WAYS_DEF,
  parameter int unsigned ADDR_WIDTH   = slc_pkg::ADDR_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  slc_pkg::cmd_t                    cmd_i,
  input  logic                             cfg_we_i,
  input  logic [slc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [slc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [slc_pkg::OP_W-1:0]         operation_i,
  input  logic [ADDR_WIDTH-1:0]            address_i,
  output slc_pkg::result_t                 result_o
);

  localparam int unsigned SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int unsigned SETS   = 1 << MAX_SET_BITS;
  localparam int unsigned WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_WAYS + 1);
  localparam int unsigned LINE_W = 1 + ADDR_WIDTH + WAY_W;
  localparam int unsigned ROW_W  = MAX_WAYS * LINE_W;
  localparam int unsigned SH_W   = $clog2((1 << slc_pkg::BLOCK_BITS_W) + MAX_SET_BITS + 1);
  localparam int unsigned TW     = slc_pkg::TOTAL_W;

  // Config registers
  logic [slc_pkg::SET_BITS_W-1:0]   set_bits_q, set_bits_d;
  logic [slc_pkg::WAYS_W-1:0]       ways_q, ways_d;
  logic [slc_pkg::BLOCK_BITS_W-1:0] block_bits_q, block_bits_d;
  logic                             cfg_clear;

  // Address split
  logic [SH_W-1:0]       s_eff, bb, tag_sh;
  logic [ADDR_WIDTH-1:0] addr_set, tag_in;
  logic [SET_W-1:0]      set_mask, set_idx;

  // Latched word
  logic [ADDR_WIDTH-1:0]       tag_q;
  logic [SET_W-1:0]            set_q;
  logic [slc_pkg::OP_W-1:0]    op_q;
  logic                        rowv_q;
  logic [SETS-1:0]             row_valid_q;

  // Lookup
  logic [ROW_W-1:0]      row_rd, row_wr;
  logic [CNT_W-1:0]      nways;
  logic [MAX_WAYS-1:0]   way_v, way_act, way_hit, way_free, way_lru;
  logic [ADDR_WIDTH-1:0] way_tag [MAX_WAYS];
  logic [WAY_W-1:0]      way_rank [MAX_WAYS];
  logic [WAY_W-1:0]      hit_way, free_way, lru_way, slot, slot_rank;
  logic                  any_hit, any_free, evict;
  logic                  is_fetch, is_modify, upd;
  logic [1:0]            hit_inc;

  // Totals and result flags
  logic [TW-1:0] hits_q, misses_q, evicts_q;
  logic          hit_q, miss_q, evict_q, second_q;

  function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] v, input logic [1:0] inc);
    logic [TW:0] sum;
    sum = {1'b0, v} + (TW + 1)'(inc);
    return sum[TW] ? {TW{1'b1}} : sum[TW-1:0];
  endfunction

  // Config decode; any register write clears the store and totals
  always_comb begin
    set_bits_d   = set_bits_q;
    ways_d       = ways_q;
    block_bits_d = block_bits_q;
    cfg_clear    = 1'b0;
    if (cfg_we_i) begin
      case (cfg_index_i)
        slc_pkg::REG_SET_BITS: begin
          set_bits_d = cfg_data_i[slc_pkg::SET_BITS_W-1:0];
          cfg_clear  = 1'b1;
        end
        slc_pkg::REG_WAYS: begin
          ways_d    = cfg_data_i[slc_pkg::WAYS_W-1:0];
          cfg_clear = 1'b1;
        end
        slc_pkg::REG_BLOCK_BITS: begin
          block_bits_d = cfg_data_i[slc_pkg::BLOCK_BITS_W-1:0];
          cfg_clear    = 1'b1;
        end
        default: begin
          cfg_clear = 1'b0;
        end
      endcase
    end
  end

  // Tag / set split of the incoming word
  always_comb begin
    s_eff    = (int'(set_bits_q) > MAX_SET_BITS) ? SH_W'(MAX_SET_BITS) : SH_W'(set_bits_q);
    bb       = SH_W'(block_bits_q);
    tag_sh   = bb + s_eff;
    addr_set = (bb >= SH_W'(ADDR_WIDTH)) ? '0 : (address_i >> bb);
    set_mask = ~({SET_W{1'b1}} << s_eff);
    set_idx  = addr_set[SET_W-1:0] & set_mask;
    tag_in   = (tag_sh >= SH_W'(ADDR_WIDTH)) ? '0 : (address_i >> tag_sh);
  end

  always_comb begin
    if (ways_q == '0) begin
      nways = CNT_W'(1);
    end else if (int'(ways_q) > MAX_WAYS) begin
      nways = CNT_W'(MAX_WAYS);
    end else begin
      nways = CNT_W'(ways_q);
    end
  end

  // Unpack row; a row never written since clear reads as the reset row
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (rowv_q) begin
        way_v[w]    = row_rd[w*LINE_W + LINE_W - 1];
        way_tag[w]  = row_rd[w*LINE_W + WAY_W +: ADDR_WIDTH];
        way_rank[w] = row_rd[w*LINE_W +: WAY_W];
      end else begin
        way_v[w]    = 1'b0;
        way_tag[w]  = '0;
        way_rank[w] = WAY_W'(w);
      end
      way_act[w]  = (w < int'(nways));
      way_hit[w]  = way_act[w] && way_v[w] && (way_tag[w] == tag_q);
      way_free[w] = way_act[w] && !way_v[w];
      way_lru[w]  = way_act[w] && ((CNT_W + 1)'(way_rank[w]) == (CNT_W + 1)'(nways) - 1'b1);
    end
  end

  // Way selection: first hit, else first free, else last LRU match
  always_comb begin
    hit_way  = '0;
    free_way = '0;
    lru_way  = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (way_hit[w]) begin
        hit_way = WAY_W'(w);
      end
      if (way_free[w]) begin
        free_way = WAY_W'(w);
      end
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (way_lru[w]) begin
        lru_way = WAY_W'(w);
      end
    end
    any_hit  = |way_hit;
    any_free = |way_free;
    evict    = !any_hit && !any_free;
    if (any_hit) begin
      slot = hit_way;
    end else if (any_free) begin
      slot = free_way;
    end else begin
      slot = lru_way;
    end
    slot_rank = way_rank[slot];
  end

  // Updated row: fill on miss, promote slot to MRU
  always_comb begin
    row_wr = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      logic              v;
      logic [ADDR_WIDTH-1:0] t;
      logic [WAY_W-1:0]  r;
      v = way_v[w];
      t = way_tag[w];
      r = way_rank[w];
      if (way_act[w] && (r < slot_rank)) begin
        r = r + 1'b1;
      end
      if (WAY_W'(w) == slot) begin
        r = '0;
        if (!any_hit) begin
          v = 1'b1;
          t = tag_q;
        end
      end
      row_wr[w*LINE_W +: LINE_W] = {v, t, r};
    end
  end

  assign is_fetch  = (op_q == slc_pkg::OP_FETCH);
  assign is_modify = (op_q == slc_pkg::OP_MODIFY);
  assign upd       = cmd_i.commit && !is_fetch;
  assign hit_inc   = {1'b0, any_hit} + {1'b0, is_modify};

  slc_ram #(
    .WIDTH  (ROW_W),
    .DEPTH  (SETS),
    .ADDR_W (SET_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (upd),
    .waddr_i (set_q),
    .wdata_i (row_wr),
    .re_i    (cmd_i.capture),
    .raddr_i (set_idx),
    .rdata_o (row_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   <= '0;
      ways_q       <= slc_pkg::WAYS_W'(1);
      block_bits_q <= '0;
      row_valid_q  <= '0;
      hits_q       <= '0;
      misses_q     <= '0;
      evicts_q     <= '0;
    end else begin
      set_bits_q   <= set_bits_d;
      ways_q       <= ways_d;
      block_bits_q <= block_bits_d;
      if (cfg_clear) begin
        row_valid_q <= '0;
        hits_q      <= '0;
        misses_q    <= '0;
        evicts_q    <= '0;
      end else if (upd) begin
        row_valid_q[set_q] <= 1'b1;
        hits_q             <= sat_add(hits_q, hit_inc);
        misses_q           <= sat_add(misses_q, {1'b0, !any_hit});
        evicts_q           <= sat_add(evicts_q, {1'b0, evict});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      tag_q  <= tag_in;
      set_q  <= set_idx;
      op_q   <= operation_i;
      rowv_q <= row_valid_q[set_idx];
    end
    if (cmd_i.commit) begin
      hit_q    <= !is_fetch && any_hit;
      miss_q   <= !is_fetch && !any_hit;
      evict_q  <= !is_fetch && evict;
      second_q <= is_modify;
    end
  end

  // Totals move only at a non-fetch commit (output free) or are cleared by a config write
  assign result_o.hit            = hit_q;
  assign result_o.miss           = miss_q;
  assign result_o.eviction       = evict_q;
  assign result_o.second_hit     = second_q;
  assign result_o.hit_total      = hits_q;
  assign result_o.miss_total     = misses_q;
  assign result_o.eviction_total = evicts_q;

endmodule

// ----- hdl/set_assoc_lru_cache_sim_top.sv -----
// Channel   Dir  Handshake     Word contents
// item_i    in   valid/ready   operation, address
// result_o  out  valid/ready   hit, miss, eviction, second_hit, three 32-bit totals
// cfg_i     in   valid/ready   index (0 set_bits, 1 ways, 2 block_bits), data
//
// Per word, the accept edge reads the set's row from the store RAM; then, once the output
// is free, the commit edge writes the compared row back and loads the result register.
// A new word is accepted only in idle; each makes one row read then one write (none for fetch).
// Reset clears per-row valid flops at once; no clearing pass. A config write clears them
// and the totals; cfg_i is always ready.
// While a result waits, one more word is accepted and held in lookup until it is taken.
module set_assoc_lru_cache_sim_top #(
  parameter int unsigned MAX_SET_BITS = slc_pkg::MAX_SET_BITS_DEF,
  parameter int unsigned MAX_WAYS     = slc_pkg::MAX_WAYS_DEF,
  parameter int unsigned ADDR_WIDTH   = slc_pkg::ADDR_WIDTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  slc_item_if.sink     item_i,
  slc_result_if.source result_o,
  slc_cfg_if.sink      cfg_i
);

  slc_pkg::cmd_t    cmd;
  slc_pkg::result_t res;

  // Sequencer: idle / lookup, plus the result valid flag
  slc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .cmd_o       (cmd)
  );

  // Address split, store row, way compare, LRU update, totals
  slc_dp #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .ADDR_WIDTH   (ADDR_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .operation_i (item_i.operation),
    .address_i   (item_i.address),
    .result_o    (res)
  );

  assign cfg_i.ready = 1'b1;

  assign result_o.hit            = res.hit;
  assign result_o.miss           = res.miss;
  assign result_o.eviction       = res.eviction;
  assign result_o.second_hit     = res.second_hit;
  assign result_o.hit_total      = res.hit_total;
  assign result_o.miss_total     = res.miss_total;
  assign result_o.eviction_total = res.eviction_total;

endmodule
